// ===== hdl/acsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_pkg
// Shared types and constants for the alarm clock / stopwatch display core.
// ----------------------------------------------------------------------------
package acsd_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SW_HR_W  = 7;
    localparam int TICKS_W  = 8;
    localparam int ALARM_W  = 40;
    localparam int IDX_W    = 3;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 24;
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 64;

    // alarm registers that exist; alarms past these never arm
    localparam int ALARM_REGS      = 3;
    localparam int ALARM_COUNT_DEF = 3;
    localparam int QUEUE_DEPTH     = 2;

    // register map (index = paddr[4:3])
    localparam logic [1:0] REG_ALARM0 = 2'd0;
    localparam logic [1:0] REG_ALARM1 = 2'd1;
    localparam logic [1:0] REG_ALARM2 = 2'd2;
    localparam logic [1:0] REG_TICKS  = 2'd3;

    // reset values: 2025-04-14 14:31:00 / 14:32:00 / 14:33:00, 20 ticks
    localparam logic [ALARM_W-1:0] ALARM0_RST = 40'd135914121152;
    localparam logic [ALARM_W-1:0] ALARM1_RST = 40'd135914121216;
    localparam logic [ALARM_W-1:0] ALARM2_RST = 40'd135914121280;
    localparam logic [TICKS_W-1:0] TICKS_RST  = 8'd20;

    // stopwatch limits
    localparam logic [SW_HR_W-1:0] SW_HR_MAX = 7'd99;
    localparam logic [MIN_W-1:0]   SW_MS_MAX = 6'd59;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,
        MODE_HELD  = 2'd1,
        MODE_ALARM = 2'd2,
        MODE_CLOCK = 2'd3
    } disp_mode_t;

    // classified tick handed from front to back
    typedef struct packed {
        logic                  start_edge;
        logic                  stop_edge;
        logic [ALARM_REGS-1:0] match;
        logic [HOUR_W-1:0]     hour;
        logic [MIN_W-1:0]      minute;
        logic [SEC_W-1:0]      second;
    } tick_cls_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic running;
        logic held;
        logic pop;
    } back_stat_t;

endpackage

// ===== hdl/acsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_front
// Accepts tick words, finds button edges and alarm time matches, and pushes
// the classified tick into the queue.
// ----------------------------------------------------------------------------
module acsd_front (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [acsd_pkg::IN_W-1:0]                     s_tdata,
    input  logic [acsd_pkg::ALARM_REGS-1:0][acsd_pkg::ALARM_W-1:0] alarm_regs,
    input  logic                                          q_full,
    output logic                                          q_push,
    output acsd_pkg::tick_cls_t                           q_data
);
    import acsd_pkg::*;

    logic                start_low_reg, start_low_next;
    logic                stop_low_reg, stop_low_next;
    logic                start_low, stop_low;
    logic [ALARM_W-1:0]  now_packed;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // buttons are active low; an edge is a press after a released word
    assign start_low = !s_tdata[0];
    assign stop_low  = !s_tdata[1];

    // same packing as the alarm registers
    assign now_packed = {s_tdata[15:2], s_tdata[19:16], s_tdata[24:20],
                         s_tdata[29:25], s_tdata[35:30], s_tdata[41:36]};

    always_comb begin
        start_low_next = start_low_reg;
        stop_low_next  = stop_low_reg;
        if (q_push) begin
            start_low_next = start_low;
            stop_low_next  = stop_low;
        end
        q_data.start_edge = start_low && !start_low_reg;
        q_data.stop_edge  = stop_low && !stop_low_reg;
        for (int i = 0; i < ALARM_REGS; i++) begin
            q_data.match[i] = (now_packed == alarm_regs[i]);
        end
        q_data.hour   = s_tdata[29:25];
        q_data.minute = s_tdata[35:30];
        q_data.second = s_tdata[41:36];
    end

    // previous button levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_low_reg <= 1'b0;
            stop_low_reg  <= 1'b0;
        end else begin
            start_low_reg <= start_low_next;
            stop_low_reg  <= stop_low_next;
        end
    end

endmodule

// ===== hdl/acsd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_fifo
// Short queue between front and back; head is readable in the same cycle.
// ----------------------------------------------------------------------------
module acsd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/acsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_back
// Runs the stopwatch and alarm countdowns for each classified tick and
// holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
module acsd_back #(
    parameter int ALARM_COUNT = acsd_pkg::ALARM_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_empty,
    input  acsd_pkg::tick_cls_t                q_head,
    output logic                               q_pop,
    input  logic [acsd_pkg::TICKS_W-1:0]       alarm_ticks,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [acsd_pkg::OUT_W-1:0]         m_tdata,
    output acsd_pkg::back_stat_t               status
);
    import acsd_pkg::*;

    logic                  running_reg, running_next;
    logic                  held_reg, held_next;
    logic [1:0]            quarter_reg, quarter_next;
    logic [SW_HR_W-1:0]    hours_reg, hours_next;
    logic [MIN_W-1:0]      minutes_reg, minutes_next;
    logic [SEC_W-1:0]      seconds_reg, seconds_next;
    logic [ALARM_COUNT-1:0] on_reg, on_next;
    logic [TICKS_W-1:0]    left_reg [ALARM_COUNT];
    logic [TICKS_W-1:0]    left_next [ALARM_COUNT];
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_word_reg, out_word_next;
    logic [ALARM_COUNT-1:0] arm_match;
    logic                  found;
    disp_mode_t            mode;
    logic [SW_HR_W-1:0]    show_h;
    logic [MIN_W-1:0]      show_m;
    logic [SEC_W-1:0]      show_s;
    logic [IDX_W-1:0]      show_idx;

    assign q_pop    = !q_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign status   = '{running: running_reg, held: held_reg, pop: q_pop};

    // per-tick update of stopwatch, alarms and display choice
    always_comb begin
        running_next = running_reg;
        held_next    = held_reg;
        quarter_next = quarter_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        on_next      = on_reg;
        left_next    = left_reg;
        arm_match    = '0;
        found        = 1'b0;
        mode         = MODE_CLOCK;
        show_h       = '0;
        show_m       = '0;
        show_s       = '0;
        show_idx     = '0;

        // start button toggles, clearing on turn-on
        if (q_head.start_edge) begin
            running_next = !running_next;
            held_next    = 1'b0;
            if (running_next) begin
                quarter_next = '0;
                hours_next   = '0;
                minutes_next = '0;
                seconds_next = '0;
            end
        end

        // stop button freezes a running stopwatch
        if (q_head.stop_edge && running_next) begin
            running_next = 1'b0;
            held_next    = 1'b1;
        end

        // one second per four running ticks, saturating at 99:59:59
        if (running_next) begin
            quarter_next = quarter_next + 2'd1;
            if (quarter_next == 2'd0 &&
                !(hours_next >= SW_HR_MAX && minutes_next >= SW_MS_MAX &&
                  seconds_next >= SW_MS_MAX)) begin
                if (seconds_next < SW_MS_MAX) begin
                    seconds_next = seconds_next + 1'b1;
                end else begin
                    seconds_next = '0;
                    if (minutes_next < SW_MS_MAX) begin
                        minutes_next = minutes_next + 1'b1;
                    end else begin
                        minutes_next = '0;
                        hours_next   = hours_next + 1'b1;
                    end
                end
            end
        end

        // arm idle alarms on an exact time match
        for (int i = 0; i < ALARM_COUNT && i < ALARM_REGS; i++) begin
            arm_match[i] = q_head.match[i];
        end
        for (int i = 0; i < ALARM_COUNT; i++) begin
            if (!on_next[i] && arm_match[i]) begin
                on_next[i]   = 1'b1;
                left_next[i] = alarm_ticks;
            end
        end

        // display priority: running, held, first active alarm, clock
        if (running_next || held_next) begin
            mode   = running_next ? MODE_RUN : MODE_HELD;
            show_h = hours_next;
            show_m = minutes_next;
            show_s = seconds_next;
        end else begin
            for (int i = 0; i < ALARM_COUNT; i++) begin
                if (!found && on_next[i]) begin
                    found    = 1'b1;
                    show_idx = IDX_W'(i);
                    if (left_next[i] <= 8'd1) begin
                        left_next[i] = '0;
                        on_next[i]   = 1'b0;
                    end else begin
                        left_next[i] = left_next[i] - 1'b1;
                    end
                end
            end
            if (found) begin
                mode = MODE_ALARM;
            end else begin
                show_h = SW_HR_W'(q_head.hour);
                show_m = q_head.minute;
                show_s = q_head.second;
            end
        end

        // output register
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_word_next  = {show_idx, show_s, show_m, show_h, mode};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            held_reg      <= 1'b0;
            quarter_reg   <= '0;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            on_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                left_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                running_reg <= running_next;
                held_reg    <= held_next;
                quarter_reg <= quarter_next;
                hours_reg   <= hours_next;
                minutes_reg <= minutes_next;
                seconds_reg <= seconds_next;
                on_reg      <= on_next;
                left_reg    <= left_next;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
    end

endmodule

// ===== hdl/alarm_clock_stopwatch_display_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_stopwatch_display_core
// Display selection for an alarm clock with stopwatch, one word per tick.
// ----------------------------------------------------------------------------
// Each input word is one 250 ms tick carrying the two active-low button
// levels and the calendar time; each produces exactly one result word that
// says what the display shows (running stopwatch, held stopwatch, first
// active alarm, or clock). The core takes one word per clock while the
// queue has room; the front classifies each accepted tick into a two-entry
// queue and the back pops it, updates the stopwatch and alarm state and
// loads the output register. The queue and the output register let input
// and output stall independently. Alarm registers and the alarm
// duration are written over the APB port at byte addresses 0, 8, 16 and 24.
module alarm_clock_stopwatch_display_core #(
    parameter int ALARM_COUNT = acsd_pkg::ALARM_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] start_pin, [1] stop_pin, [15:2] now_year, [19:16] now_month,
    // [24:20] now_day, [29:25] now_hour, [35:30] now_minute,
    // [41:36] now_second, [47:42] zero
    input  logic [acsd_pkg::IN_W-1:0]     s_tdata,
    // display result
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] display_mode, [8:2] show_hours, [14:9] show_minutes,
    // [20:15] show_seconds, [23:21] alarm_index
    output logic [acsd_pkg::OUT_W-1:0]    m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acsd_pkg::CFG_AW-1:0]   paddr,
    input  logic [acsd_pkg::CFG_DW-1:0]   pwdata,
    output logic [acsd_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import acsd_pkg::*;

    logic [ALARM_REGS-1:0][ALARM_W-1:0] alarm_reg;
    logic [TICKS_W-1:0]                 ticks_reg;
    logic [1:0]                         cfg_idx;
    logic                               cfg_wr;
    logic                               q_push, q_pop, q_full, q_empty;
    tick_cls_t                          q_in, q_head;
    back_stat_t                         back_stat;

    // register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg[0] <= ALARM0_RST;
            alarm_reg[1] <= ALARM1_RST;
            alarm_reg[2] <= ALARM2_RST;
            ticks_reg    <= TICKS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ALARM0: alarm_reg[0] <= pwdata[ALARM_W-1:0];
                REG_ALARM1: alarm_reg[1] <= pwdata[ALARM_W-1:0];
                REG_ALARM2: alarm_reg[2] <= pwdata[ALARM_W-1:0];
                REG_TICKS:  ticks_reg    <= pwdata[TICKS_W-1:0];
                default:    ticks_reg    <= ticks_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ALARM0: prdata = CFG_DW'(alarm_reg[0]);
            REG_ALARM1: prdata = CFG_DW'(alarm_reg[1]);
            REG_ALARM2: prdata = CFG_DW'(alarm_reg[2]);
            REG_TICKS:  prdata = CFG_DW'(ticks_reg);
            default:    prdata = '0;
        endcase
    end

    // front: edges and alarm matches
    acsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .alarm_regs (alarm_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    // queue between front and back
    acsd_fifo #(
        .WIDTH ($bits(tick_cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back: stopwatch, alarms, result register
    acsd_back #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .alarm_ticks (ticks_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .status      (back_stat)
    );

    // stopwatch is never running and held at once
    a_run_held_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(back_stat.running && back_stat.held))
        else $error("stopwatch running and held together");

    // a new result appears only after a queue pop
    a_out_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(back_stat.pop))
        else $error("result without a dequeued tick");

    // alarm results name an existing alarm
    a_alarm_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == MODE_ALARM) |->
        (m_tdata[23:21] < IDX_W'(ALARM_COUNT)))
        else $error("alarm index out of range");

endmodule

// ===== bench/tb_alarm_clock_stopwatch_display_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_clock_stopwatch_display_core
// Self-checking bench for the alarm clock / stopwatch display core.
// ----------------------------------------------------------------------------
// Tick words go in on the s_ stream and display words come out on the m_
// stream. A scoreboard class keeps its own copy of the stopwatch, button
// and alarm state plus the alarm registers, predicts one display word per
// accepted tick, and compares each delivered word field by field. A short
// directed run covers the button edges, alarm arming and priority and the
// field extremes. Random runs follow under several register settings,
// with random gaps on the input and random back-pressure on the output.
// Every register write is read back over APB.
module tb_alarm_clock_stopwatch_display_core;
    import acsd_pkg::*;

    // tick word, lowest field last
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               stop_n;
        logic               start_n;
    } tick_t;

    // calendar stamp in alarm register layout
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } stamp_t;

    // display word, lowest field last
    typedef struct packed {
        logic [IDX_W-1:0]   alarm_index;
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [SW_HR_W-1:0] hours;
        disp_mode_t         mode;
    } display_t;

    // ------------------------------------------------------------------------
    // display predictor and result store
    // ------------------------------------------------------------------------
    class display_board;
        stamp_t             alarm_reg [ALARM_REGS];
        logic [TICKS_W-1:0] alarm_ticks;
        logic               start_down, stop_down, running, held;
        logic [1:0]         quarter;
        logic [SW_HR_W-1:0] sw_hrs;
        logic [MIN_W-1:0]   sw_mins;
        logic [SEC_W-1:0]   sw_secs;
        logic               alarm_on   [ALARM_REGS];
        logic [TICKS_W-1:0] alarm_left [ALARM_REGS];
        display_t           pending [$];
        int                 errors;
        int                 ticks_seen;
        int                 words_seen;
        int                 mode_count [4];

        function new();
            alarm_reg[0] = stamp_t'(ALARM0_RST);
            alarm_reg[1] = stamp_t'(ALARM1_RST);
            alarm_reg[2] = stamp_t'(ALARM2_RST);
            alarm_ticks  = TICKS_RST;
            start_down   = 1'b0;
            stop_down    = 1'b0;
            running      = 1'b0;
            held         = 1'b0;
            quarter      = '0;
            sw_hrs       = '0;
            sw_mins      = '0;
            sw_secs      = '0;
            foreach (alarm_on[i]) begin
                alarm_on[i]   = 1'b0;
                alarm_left[i] = '0;
            end
            foreach (mode_count[i]) mode_count[i] = 0;
            errors     = 0;
            ticks_seen = 0;
            words_seen = 0;
        endfunction

        task report(string what);
            errors++;
            $display("%0t ns  error: %s", $time, what);
        endtask

        function void write_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
            if (idx == REG_TICKS) alarm_ticks = value[TICKS_W-1:0];
            else alarm_reg[idx] = stamp_t'(value[ALARM_W-1:0]);
        endfunction

        // one second up, holding at 99:59:59
        function void add_second();
            if (sw_hrs >= SW_HR_MAX && sw_mins >= SW_MS_MAX && sw_secs >= SW_MS_MAX) return;
            if (sw_secs < SW_MS_MAX) begin
                sw_secs = sw_secs + 1'b1;
                return;
            end
            sw_secs = '0;
            if (sw_mins < SW_MS_MAX) begin
                sw_mins = sw_mins + 1'b1;
                return;
            end
            sw_mins = '0;
            sw_hrs  = sw_hrs + 1'b1;
        endfunction

        function void note_tick(tick_t t);
            stamp_t   now;
            display_t want;
            int       act;
            now = {t.year, t.month, t.day, t.hour, t.minute, t.second};

            // start button: toggle on press edge, fresh count when turned on
            if (!t.start_n) begin
                if (!start_down) begin
                    running = !running;
                    held    = 1'b0;
                    if (running) begin
                        quarter = '0;
                        sw_hrs  = '0;
                        sw_mins = '0;
                        sw_secs = '0;
                    end
                    start_down = 1'b1;
                end
            end else begin
                start_down = 1'b0;
            end

            // stop button: freeze a running stopwatch on press edge
            if (!t.stop_n) begin
                if (!stop_down) begin
                    if (running) begin
                        running = 1'b0;
                        held    = 1'b1;
                    end
                    stop_down = 1'b1;
                end
            end else begin
                stop_down = 1'b0;
            end

            if (running) begin
                quarter = quarter + 2'd1;
                if (quarter == 2'd0) add_second();
            end

            // arm idle alarms on exact match
            for (int i = 0; i < ALARM_REGS; i++) begin
                if (!alarm_on[i] && now == alarm_reg[i]) begin
                    alarm_on[i]   = 1'b1;
                    alarm_left[i] = alarm_ticks;
                end
            end

            // pick what the display shows
            want = '0;
            if (running || held) begin
                want.mode    = running ? MODE_RUN : MODE_HELD;
                want.hours   = sw_hrs;
                want.minutes = sw_mins;
                want.seconds = sw_secs;
            end else begin
                act = -1;
                for (int i = 0; i < ALARM_REGS; i++) begin
                    if (act < 0 && alarm_on[i]) act = i;
                end
                if (act >= 0) begin
                    want.mode        = MODE_ALARM;
                    want.alarm_index = IDX_W'(act);
                    if (alarm_left[act] <= 1) begin
                        alarm_left[act] = '0;
                        alarm_on[act]   = 1'b0;
                    end else begin
                        alarm_left[act] = alarm_left[act] - 1'b1;
                    end
                end else begin
                    want.mode    = MODE_CLOCK;
                    want.hours   = SW_HR_W'(t.hour);
                    want.minutes = t.minute;
                    want.seconds = t.second;
                end
            end
            mode_count[want.mode]++;
            ticks_seen++;
            pending.push_back(want);
        endfunction

        task check_display(display_t got);
            display_t want;
            words_seen++;
            if (pending.size() == 0) begin
                report($sformatf("display word %h arrived with no tick pending", got));
            end else begin
                want = pending.pop_front();
                if (got.mode !== want.mode)
                    report($sformatf("word %0d: mode %0d, expected %0d",
                                     words_seen, got.mode, want.mode));
                if (got.hours !== want.hours)
                    report($sformatf("word %0d: hours %0d, expected %0d",
                                     words_seen, got.hours, want.hours));
                if (got.minutes !== want.minutes)
                    report($sformatf("word %0d: minutes %0d, expected %0d",
                                     words_seen, got.minutes, want.minutes));
                if (got.seconds !== want.seconds)
                    report($sformatf("word %0d: seconds %0d, expected %0d",
                                     words_seen, got.seconds, want.seconds));
                if (got.alarm_index !== want.alarm_index)
                    report($sformatf("word %0d: alarm index %0d, expected %0d",
                                     words_seen, got.alarm_index, want.alarm_index));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CFG_AW-1:0]   paddr    = '0;
    logic [CFG_DW-1:0]   pwdata   = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    display_board board;
    bit           gaps_on    = 1'b1;
    int           ready_hold = 0;
    int           reads_done = 0;

    alarm_clock_stopwatch_display_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    // idle stretch: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        else if (r < 90) return $urandom_range(3, 8);
        else if (r < 98) return $urandom_range(9, 20);
        else return $urandom_range(30, 80);
    endfunction

    function automatic stamp_t stamp(int y, int mo, int d, int h, int mi, int s);
        return {YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h), MIN_W'(mi), SEC_W'(s)};
    endfunction

    function automatic stamp_t rand_stamp();
        return stamp($urandom_range(0, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    function automatic tick_t make_tick(logic start_n, logic stop_n, stamp_t at);
        tick_t t;
        t.start_n = start_n;
        t.stop_n  = stop_n;
        t.year    = at.year;
        t.month   = at.month;
        t.day     = at.day;
        t.hour    = at.hour;
        t.minute  = at.minute;
        t.second  = at.second;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // tick driver
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_t t);
        int gap;
        gap = (gaps_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(t);
        do @(posedge aclk); while (!s_tready);
        board.note_tick(t);
    endtask

    // stop sending and let every pending word come out
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (board.pending.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (6) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------
    task automatic reg_check(logic [1:0] idx);
        logic [CFG_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        want = (idx == REG_TICKS) ? CFG_DW'(board.alarm_ticks) : CFG_DW'(board.alarm_reg[idx]);
        if (prdata !== want)
            board.report($sformatf("register %0d read %h, expected %h", idx, prdata, want));
        reads_done++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        reg_check(idx);
    endtask

    // ------------------------------------------------------------------------
    // random ticks: button press/release runs with alarm hits and noise
    // ------------------------------------------------------------------------
    task automatic run_random(int count);
        logic   start_lvl, stop_lvl;
        int     rate, r;
        stamp_t at;
        start_lvl = 1'b1;
        stop_lvl  = 1'b1;
        rate      = 6;
        for (int k = 0; k < count; k++) begin
            // new burst: gap policy and how often buttons change
            if (k % 100 == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 2))
                    0: rate = 6;
                    1: rate = 25;
                    default: rate = 400;
                endcase
            end
            if ($urandom_range(1, rate) == 1) start_lvl = !start_lvl;
            if ($urandom_range(1, rate) == 1) stop_lvl = !stop_lvl;
            if ($urandom_range(0, 19) == 0) begin
                start_lvl = 1'($urandom_range(0, 1));
                stop_lvl  = 1'($urandom_range(0, 1));
            end
            r = $urandom_range(0, 99);
            if (r < 25) at = board.alarm_reg[$urandom_range(0, ALARM_REGS - 1)];
            else if (r < 35) at = stamp_t'(ALARM_W'({$urandom, $urandom}));
            else at = rand_stamp();
            send_tick(make_tick(start_lvl, stop_lvl, at));
        end
    endtask

    // ------------------------------------------------------------------------
    // output back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!m_tready) begin
            m_tready   <= 1'b1;
            ready_hold <= ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 15);
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= idle_len() - 1;
        end
    end

    // display word monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_display(display_t'(m_tdata));
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        stamp_t base, ones, zero;
        stamp_t same;
        board = new();
        base  = stamp(2025, 4, 14, 14, 33, 1);
        ones  = '1;
        zero  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of all registers
        reg_check(REG_ALARM0);
        reg_check(REG_ALARM1);
        reg_check(REG_ALARM2);
        reg_check(REG_TICKS);

        // directed: clock extremes, alarm priority, button edges
        send_tick(make_tick(1'b1, 1'b1, stamp(2025, 4, 14, 14, 30, 59)));
        send_tick(make_tick(1'b1, 1'b1, zero));
        send_tick(make_tick(1'b1, 1'b1, ones));
        send_tick(make_tick(1'b1, 1'b1, stamp(2025, 4, 14, 14, 31, 0)));
        send_tick(make_tick(1'b1, 1'b1, stamp(2025, 4, 14, 14, 33, 0)));
        // start press held four ticks: first stopwatch second
        send_tick(make_tick(1'b0, 1'b1, base));
        send_tick(make_tick(1'b0, 1'b1, base));
        send_tick(make_tick(1'b0, 1'b1, base));
        send_tick(make_tick(1'b0, 1'b1, base));
        // stop edge freezes, stop edge while frozen does nothing
        send_tick(make_tick(1'b1, 1'b0, base));
        send_tick(make_tick(1'b1, 1'b0, base));
        send_tick(make_tick(1'b1, 1'b1, base));
        send_tick(make_tick(1'b1, 1'b0, base));
        // start from frozen restarts; start while running turns it off
        send_tick(make_tick(1'b0, 1'b1, base));
        send_tick(make_tick(1'b1, 1'b1, base));
        send_tick(make_tick(1'b0, 1'b1, base));
        // stop edge while off, then a second alarm behind the first
        send_tick(make_tick(1'b0, 1'b0, base));
        send_tick(make_tick(1'b1, 1'b1, stamp(2025, 4, 14, 14, 32, 0)));
        // both edges in one tick: start then freeze at zero
        send_tick(make_tick(1'b0, 1'b0, ones));
        send_tick(make_tick(1'b1, 1'b1, ones));
        drain();

        // random phases under different register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    set_reg(REG_ALARM0, {$urandom, $urandom});
                    set_reg(REG_ALARM1, CFG_DW'(rand_stamp()));
                    set_reg(REG_ALARM2, CFG_DW'(rand_stamp()));
                    set_reg(REG_TICKS, CFG_DW'(1));
                end
                1: begin
                    set_reg(REG_ALARM0, '0);
                    set_reg(REG_ALARM1, CFG_DW'(ones));
                    set_reg(REG_ALARM2, CFG_DW'(rand_stamp()));
                    set_reg(REG_TICKS, CFG_DW'(255));
                end
                2: begin
                    // all alarms on one stamp, zero duration
                    same = rand_stamp();
                    set_reg(REG_ALARM0, CFG_DW'(same));
                    set_reg(REG_ALARM1, CFG_DW'(same));
                    set_reg(REG_ALARM2, CFG_DW'(same));
                    set_reg(REG_TICKS, '0);
                end
                3: begin
                    set_reg(REG_ALARM0, CFG_DW'(rand_stamp()));
                    set_reg(REG_ALARM1, CFG_DW'(rand_stamp()));
                    set_reg(REG_ALARM2, CFG_DW'(rand_stamp()));
                    set_reg(REG_TICKS, CFG_DW'($urandom_range(2, 40)));
                end
                default: begin
                    set_reg(REG_ALARM0, {$urandom, $urandom});
                    set_reg(REG_ALARM1, {$urandom, $urandom});
                    set_reg(REG_ALARM2, {$urandom, $urandom});
                    set_reg(REG_TICKS, {$urandom, $urandom});
                end
            endcase
            run_random(390);
            drain();
        end

        if (board.pending.size() != 0)
            board.report($sformatf("%0d display words never arrived", board.pending.size()));
        $display("%0d ticks under six register settings, %0d register reads",
                 board.ticks_seen, reads_done);
        $display("displays: %0d running, %0d held, %0d alarm, %0d clock; %0d errors",
                 board.mode_count[MODE_RUN], board.mode_count[MODE_HELD],
                 board.mode_count[MODE_ALARM], board.mode_count[MODE_CLOCK], board.errors);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #4_000_000;
        $display("run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
